### hdl/adm_pkg.sv
// Shared types, constants and fixed-point helpers for the admittance filter.
`timescale 1ns / 1ps

package adm_pkg;

  localparam int AXES_DEFAULT = 6;
  localparam int LINEAR_AXES  = 3;

  localparam logic [30:0] INV_MASS_RESET  = 31'd65536;
  localparam logic [30:0] DAMPING_RESET   = 31'd983040;
  localparam logic [30:0] STIFFNESS_RESET = 31'd983040;
  localparam logic [16:0] STEP_TIME_RESET = 17'd328;

  // configuration register indexes
  localparam logic [1:0] REG_INV_MASS  = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_STIFFNESS = 2'd2;
  localparam logic [1:0] REG_STEP_TIME = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } state_entry_t;

  // Q16.16 rescale of a full product: round to nearest, ties up
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/admittance_filter_six_axis.sv
// Admittance filter top level: sequencer, configuration registers and output register.
// An item is taken only in idle and runs through write-back before the next is taken; an
// axis out of range goes straight to write-back. The single shared multiplier runs five
// products per item (damping, stiffness, inverse mass, two Euler steps), the last three
// each dependent on the one before. Reset: synchronous; axis offsets read as zero, gains
// take defaults. The next item is accepted while a finished result waits on the output.
`timescale 1ns / 1ps

module admittance_filter_six_axis
  import adm_pkg::*;
#(
  parameter int AXES = AXES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         axis,
  input  logic signed [31:0] wrench,
  input  logic signed [31:0] desired_position,
  input  logic signed [31:0] desired_velocity,
  input  logic signed [31:0] desired_accel,
  input  logic               wrench_seen,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_axis,
  output logic signed [31:0] compliant_position,
  output logic signed [31:0] compliant_velocity,
  output logic signed [31:0] compliant_accel
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MK, S_SUM, S_MM, S_ACC, S_MT1, S_VEL, S_MT2, S_POS, S_WB
  } state_t;

  state_t state;

  logic [30:0] inv_mass, damping, stiffness;
  logic [16:0] step_time;

  logic [2:0]         axis_q;
  logic               in_range;
  logic signed [31:0] wr_q, dp_q, dv_q, da_q;
  logic               seen_q;
  logic signed [31:0] vel_q, pos_q, acc_q, vel_new, pos_new;
  logic signed [63:0] force_q;

  logic               in_beat, out_free, wb_go, axis_ok;
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod, prod_r;
  state_entry_t       rd_data, wr_data;
  logic signed [31:0] pos_out, vel_out, acc_out;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wb_go    = (state == S_WB) && out_free;
  assign axis_ok  = ({1'b0, axis} < 4'(AXES));
  assign prod_r   = rnd_q16(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass  <= INV_MASS_RESET;
      damping   <= DAMPING_RESET;
      stiffness <= STIFFNESS_RESET;
      step_time <= STEP_TIME_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INV_MASS:  inv_mass  <= cfg_data;
        REG_DAMPING:   damping   <= cfg_data;
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_STEP_TIME: step_time <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_RD: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, damping};
        mul_b  = rd_data.vel;
      end
      S_MK: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, stiffness};
        mul_b  = pos_q;
      end
      S_MM: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, inv_mass};
        mul_b  = sat32(force_q);
      end
      S_MT1: begin
        mul_en = 1'b1;
        mul_a  = acc_q;
        mul_b  = {15'd0, step_time};
      end
      S_MT2: begin
        mul_en = 1'b1;
        mul_a  = vel_new;
        mul_b  = {15'd0, step_time};
      end
      default: ;
    endcase
  end

  adm_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign wr_data.pos = pos_new;
  assign wr_data.vel = vel_new;

  // read happens at the accept edge; write only at write-back, so no overlap
  adm_mem #(.AXES(AXES), .AW(AW)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_beat && axis_ok),
    .rd_addr (axis[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wb_go && in_range),
    .wr_addr (axis_q[AW-1:0]),
    .wr_data (wr_data)
  );

  always_comb begin
    if ({1'b0, axis_q} < 4'(LINEAR_AXES)) begin
      pos_out = sat32(64'(dp_q) + 64'(pos_new));
    end else begin
      pos_out = pos_new;
    end
    vel_out = sat32(64'(dv_q) + 64'(vel_new));
    acc_out = sat32(64'(da_q) + 64'(acc_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !wb_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            axis_q   <= axis;
            in_range <= axis_ok;
            wr_q     <= wrench;
            dp_q     <= desired_position;
            dv_q     <= desired_velocity;
            da_q     <= desired_accel;
            seen_q   <= wrench_seen;
            state    <= axis_ok ? S_RD : S_WB;
          end
        end
        S_RD: begin
          vel_q <= rd_data.vel;
          pos_q <= rd_data.pos;
          state <= S_MK;
        end
        S_MK: begin
          force_q <= 64'(wr_q) - prod_r;
          state   <= S_SUM;
        end
        S_SUM: begin
          force_q <= force_q - prod_r;
          state   <= S_MM;
        end
        S_MM: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc_q <= seen_q ? sat32(prod_r) : 32'sd0;
          state <= S_MT1;
        end
        S_MT1: begin
          state <= S_VEL;
        end
        S_VEL: begin
          vel_new <= sat32(64'(vel_q) + prod_r);
          state   <= S_MT2;
        end
        S_MT2: begin
          state <= S_POS;
        end
        S_POS: begin
          pos_new <= sat32(64'(pos_q) + prod_r);
          state   <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_axis  <= axis_q;
            if (in_range) begin
              compliant_position <= pos_out;
              compliant_velocity <= vel_out;
              compliant_accel    <= acc_out;
            end else begin
              compliant_position <= '0;
              compliant_velocity <= '0;
              compliant_accel    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("input accepted while a beat is still in work");

  a_result_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WB))
    else $error("result raised outside write-back");

  a_axis_echo: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_axis == $past(axis_q))
    else $error("echoed axis does not match captured axis");

  a_no_write_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (wb_go && in_range) |-> ({1'b0, axis_q} < 4'(AXES)))
    else $error("offset write for an axis out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_axis))
    else $error("pending result overwritten");

endmodule

### hdl/adm_mem.sv
// Per-axis offset store: synchronous RAM with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module adm_mem
  import adm_pkg::*;
#(
  parameter int AXES = AXES_DEFAULT,
  parameter int AW   = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output state_entry_t rd_data,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  state_entry_t wr_data
);

  state_entry_t     mem [AXES];
  logic [AXES-1:0]  valid;
  state_entry_t     rd_raw;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // never-written entries read as zero offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

### hdl/adm_mul.sv
// Shared signed 32x32 multiplier with registered 64-bit product.
`timescale 1ns / 1ps

module adm_mul
  import adm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule
